// File: rtl/core/pli_pkg.sv
// Shared types and codes for the positional list block.
package pli_pkg;

	localparam int POS_W = 8;
	localparam int VAL_W = 32;
	localparam int LEN_W = 5;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_DELETE = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_INS,
		OP_DEL
	} shift_op_t;

	typedef struct packed {
		shift_op_t        op;
		logic [POS_W-1:0] pidx;
	} shift_cmd_t;

endpackage

// File: rtl/core/pli_cell.sv
// One storage cell of the list: holds an entry and shifts with its neighbors.
module pli_cell #(
	parameter int DATA_WIDTH = 32,
	parameter int INDEX      = 0
) (
	input  logic                    clk,
	input  pli_pkg::shift_cmd_t     cmd,
	input  logic [DATA_WIDTH-1:0]   value_ins,
	input  logic [DATA_WIDTH-1:0]   left_data,
	input  logic [DATA_WIDTH-1:0]   right_data,
	output logic [DATA_WIDTH-1:0]   data
);

	localparam logic [pli_pkg::POS_W-1:0] IDX = pli_pkg::POS_W'(INDEX);

	logic [DATA_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			pli_pkg::OP_INS: begin
				if (IDX == cmd.pidx) begin
					data_q <= value_ins;
				end else if (IDX > cmd.pidx) begin
					data_q <= left_data;
				end
			end
			pli_pkg::OP_DEL: begin
				if (IDX >= cmd.pidx) begin
					data_q <= right_data;
				end
			end
			default: begin
			end
		endcase
	end

	assign data = data_q;

endmodule

// File: rtl/core/positional_list_insert_delete_top.sv
// Top level of the positional list: insert, delete and read at a one-based position.
// The result beat comes from the result register, valid in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while results are taken; every cell shifts in parallel in the cycle of accept.
// Input is taken while a finished result waits if the result is taken that same cycle.
// Reset (arst_n low, asynchronous) clears the count and the result valid; cell
// contents are not reset and are only read after being written.
module positional_list_insert_delete_top #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // position[7:0], value_in[39:8]
	input  logic [1:0]  s_axis_tuser,  // mode[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // value_out[31:0], length[36:32], zero[39:37]
	output logic [1:0]  m_axis_tuser   // status[1:0]
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [pli_pkg::POS_W-1:0]    position;
	logic signed [pli_pkg::VAL_W-1:0] value_in;
	logic [1:0]                   mode;
	logic                         acc;

	logic [CW-1:0]                count_q;
	logic [CW-1:0]                count_nxt;
	logic [9:0]                   pos10;
	logic [9:0]                   cnt10;
	logic                         ok_ins;
	logic                         ok_rd;
	logic                         full;

	pli_pkg::shift_cmd_t          cmd;
	pli_pkg::shift_op_t           op_sel;
	logic [1:0]                   status;
	logic                         take_rd;

	logic [DATA_WIDTH-1:0]        cell_data [CAPACITY];
	logic [DATA_WIDTH-1:0]        rd_data;
	logic [DATA_WIDTH+31:0]       val_ext;
	logic [DATA_WIDTH-1:0]        val_ins;
	logic [63:0]                  rd_ext;
	logic [CW+4:0]                len_ext;

	logic                         out_valid_q;
	logic [1:0]                   status_q;
	logic [pli_pkg::VAL_W-1:0]    vout_q;
	logic [pli_pkg::LEN_W-1:0]    len_q;

	assign position = s_axis_tdata[7:0];
	assign value_in = s_axis_tdata[39:8];
	assign mode     = s_axis_tuser;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign acc           = s_axis_tvalid && s_axis_tready;

	assign pos10  = 10'(position);
	assign cnt10  = 10'(count_q);
	assign ok_ins = (position != '0) && (pos10 <= cnt10 + 10'd1);
	assign ok_rd  = (position != '0) && (pos10 <= cnt10);
	assign full   = (count_q == CW'(CAPACITY));

	always_comb begin
		status  = pli_pkg::ST_BADPOS;
		op_sel  = pli_pkg::OP_NONE;
		take_rd = 1'b0;
		case (mode)
			pli_pkg::MODE_INSERT: begin
				if (ok_ins) begin
					if (full) begin
						status = pli_pkg::ST_FULL;
					end else begin
						status = pli_pkg::ST_DONE;
						op_sel = pli_pkg::OP_INS;
					end
				end
			end
			pli_pkg::MODE_DELETE: begin
				if (ok_rd) begin
					status  = pli_pkg::ST_DONE;
					op_sel  = pli_pkg::OP_DEL;
					take_rd = 1'b1;
				end
			end
			pli_pkg::MODE_READ: begin
				if (ok_rd) begin
					status  = pli_pkg::ST_DONE;
					take_rd = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign cmd.op   = acc ? op_sel : pli_pkg::OP_NONE;
	assign cmd.pidx = position - pli_pkg::POS_W'(1);

	always_comb begin
		case (op_sel)
			pli_pkg::OP_INS: count_nxt = count_q + CW'(1);
			pli_pkg::OP_DEL: count_nxt = count_q - CW'(1);
			default:         count_nxt = count_q;
		endcase
	end

	// stored value keeps the low DATA_WIDTH bits, zero-filled above 32
	assign val_ext = (DATA_WIDTH + 32)'($unsigned(value_in));
	assign val_ins = val_ext[DATA_WIDTH-1:0];

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			logic [DATA_WIDTH-1:0] left_d;
			logic [DATA_WIDTH-1:0] right_d;
			if (g == 0) begin : g_first
				assign left_d = val_ins;
			end else begin : g_mid_l
				assign left_d = cell_data[g-1];
			end
			if (g == CAPACITY - 1) begin : g_last
				assign right_d = '0;
			end else begin : g_mid_r
				assign right_d = cell_data[g+1];
			end
			pli_cell #(
				.DATA_WIDTH (DATA_WIDTH),
				.INDEX      (g)
			) u_cell (
				.clk        (clk),
				.cmd        (cmd),
				.value_ins  (val_ins),
				.left_data  (left_d),
				.right_data (right_d),
				.data       (cell_data[g])
			);
		end
	endgenerate

	// one-hot AND-OR read of the addressed cell
	always_comb begin
		rd_data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (pli_pkg::POS_W'(i) == cmd.pidx) begin
				rd_data = rd_data | cell_data[i];
			end
		end
	end

	assign rd_ext  = 64'($signed(rd_data));
	assign len_ext = (CW + 5)'(count_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_q <= status;
			vout_q   <= take_rd ? rd_ext[31:0] : '0;
			len_q    <= len_ext[4:0];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tdata  = {3'b000, len_q, vout_q};

endmodule

// File: rtl/core/pli_chk.sv
// Port-level assertions for the positional list top, bound to every instance.
module pli_chk #(
	parameter int CAPACITY = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("result valid during reset");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty result register");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == pli_pkg::ST_FULL) |->
			m_axis_tdata[36:32] == 5'(CAPACITY))
		else $error("full status with length below capacity");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != pli_pkg::ST_DONE) |->
			m_axis_tdata[31:0] == 32'd0)
		else $error("nonzero value on failed operation");

endmodule

bind positional_list_insert_delete_top pli_chk #(
	.CAPACITY (CAPACITY)
) u_pli_chk (.*);
